### rtl/lfds_pkg.sv
// ----------------------------------------------------------------------------
// lfds_pkg
// Shared codes, sensor patterns and the drive clamp for the line-follow
// drive step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lfds_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_RUN  = 3'd0,
        ST_IDLE = 3'd1,
        ST_DARK = 3'd2,
        ST_HELD = 3'd3,
        ST_TAG  = 3'd4
    } t_status;

    // side lock codes
    typedef enum logic [1:0] {
        LOCK_NONE  = 2'd0,
        LOCK_RIGHT = 2'd1,
        LOCK_LEFT  = 2'd2,
        LOCK_UNUSED = 2'd3
    } t_lock;

    // configuration register indexes
    localparam logic [1:0] REG_BASE_SPEED  = 2'd0;
    localparam logic [1:0] REG_WHITE_LIMIT = 2'd1;
    localparam logic [1:0] REG_TAG_MODE    = 2'd2;
    localparam logic [1:0] REG_UPDATE_GAP  = 2'd3;

    localparam int unsigned CFG_ADDR_W = 4;

    // sensor patterns, a zero bit means line under that sensor
    localparam logic [7:0] PAT_DARK     = 8'h00;
    localparam logic [7:0] PAT_WHITE    = 8'hFF;
    localparam logic [7:0] PAT_CTR_A    = 8'hE7;
    localparam logic [7:0] PAT_CTR_B    = 8'hF7;
    localparam logic [7:0] PAT_CTR_C    = 8'hEF;
    localparam logic [7:0] PAT_R1_A     = 8'hF3;
    localparam logic [7:0] PAT_R1_B     = 8'hFB;
    localparam logic [7:0] PAT_R2_A     = 8'hF9;
    localparam logic [7:0] PAT_R2_B     = 8'hFD;
    localparam logic [7:0] PAT_R3       = 8'hFC;
    localparam logic [7:0] PAT_R_EDGE   = 8'hFE;
    localparam logic [7:0] PAT_L1       = 8'hCF;
    localparam logic [7:0] PAT_L2_A     = 8'h9F;
    localparam logic [7:0] PAT_L2_B     = 8'hDF;
    localparam logic [7:0] PAT_L3_A     = 8'h3F;
    localparam logic [7:0] PAT_L3_B     = 8'hBF;
    localparam logic [7:0] PAT_L_EDGE   = 8'h7F;

    localparam logic signed [8:0] DRIVE_MAX = 9'sd100;
    localparam logic signed [8:0] DRIVE_MIN = 9'sd5;

    // limit a wheel target to -100..-5 or 5..100
    function automatic logic signed [7:0] clamp_drive(input logic signed [8:0] v);
        logic signed [8:0] r;
        begin
            if (!v[8]) begin
                if (v > DRIVE_MAX) begin
                    r = DRIVE_MAX;
                end else if (v < DRIVE_MIN) begin
                    r = DRIVE_MIN;
                end else begin
                    r = v;
                end
            end else begin
                if (v < -DRIVE_MAX) begin
                    r = -DRIVE_MAX;
                end else if (v > -DRIVE_MIN) begin
                    r = -DRIVE_MIN;
                end else begin
                    r = v;
                end
            end
            clamp_drive = r[7:0];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/line_follow_drive_step_unit.sv
// ----------------------------------------------------------------------------
// line_follow_drive_step_unit
// Steps a line-following run: maps each sensor pattern to wheel commands,
// tracks side lock, all-white runs and the drive update gap.
// ----------------------------------------------------------------------------
// Usage: an input item (sensors, now_ms, start_req) is taken when i_in_valid
// and o_in_ready are both high. Every item gives exactly one result item
// (drive_valid, left_drive, right_drive, status), offered on o_out_valid and
// taken when i_out_ready is high.
// The item is captured in an input register, the pattern lookup, white-run
// count, gap compare and clamp are done in one pass and the result lands in
// the output register. One item per cycle is sustained while the receiver
// keeps i_out_ready high; the run state is updated as the item moves into
// the output register, so the next item already sees it.
// When the receiver stalls the output register holds; the input register
// still fills, and o_in_ready drops only when both registers are occupied.
// Synchronous active-low reset empties both registers, clears the run state
// and loads the register defaults (base 0, white limit 50, tag mode 0,
// gap 2). The user must write registers over the APB port only while no
// item is in flight; the block does not enforce this; pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_drive_step_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input item channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [7:0]                    i_sensors,
    input  wire logic [31:0]                   i_now_ms,
    input  wire logic                          i_start_req,
    // result item channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_drive_valid,
    output logic signed [7:0]                  o_left_drive,
    output logic signed [7:0]                  o_right_drive,
    output logic [2:0]                         o_status,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lfds_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import lfds_pkg::*;

    // configuration
    logic [6:0]  r_base_speed;
    logic [7:0]  r_white_limit;
    logic        r_tag_mode;
    logic [7:0]  r_update_gap;

    // run state
    logic        r_run_active, n_run_active;
    logic        r_run_held, n_run_held;
    t_lock       r_side_lock, n_side_lock;
    logic [7:0]  r_white_run, n_white_run;
    logic signed [8:0] r_left_target, n_left_target;
    logic signed [8:0] r_right_target, n_right_target;
    logic [31:0] r_last_time, n_last_time;

    // input register
    logic        r_s1_valid;
    logic [7:0]  r_s1_sensors;
    logic [31:0] r_s1_now;
    logic        r_s1_start;

    // output register
    logic        r_out_valid;
    logic        r_drive_valid, n_drive_valid;
    logic signed [7:0] r_left_drive, n_left_drive;
    logic signed [7:0] r_right_drive, n_right_drive;
    t_status     r_status, n_status;

    logic        w_out_free;
    logic        w_s1_adv;
    logic        w_cfg_wr;

    logic        w_hit;
    logic signed [8:0] w_l_off, w_r_off;
    t_lock       w_lock;
    logic        w_active, w_held;
    logic [31:0] w_due;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign o_in_ready = !r_s1_valid || w_out_free;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign pready     = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_BASE_SPEED:  prdata = {25'd0, r_base_speed};
            REG_WHITE_LIMIT: prdata = {24'd0, r_white_limit};
            REG_TAG_MODE:    prdata = {31'd0, r_tag_mode};
            REG_UPDATE_GAP:  prdata = {24'd0, r_update_gap};
            default:         prdata = 32'd0;
        endcase
    end

    // pattern to wheel offsets; the two side groups are mutually exclusive
    always_comb begin
        w_hit   = 1'b1;
        w_l_off = 9'sd0;
        w_r_off = 9'sd0;
        w_lock  = r_side_lock;
        if (r_s1_sensors == PAT_CTR_A || r_s1_sensors == PAT_CTR_B
                || r_s1_sensors == PAT_CTR_C) begin
            w_l_off = 9'sd0;
            w_r_off = 9'sd0;
        end else if (r_side_lock != LOCK_LEFT
                && (r_s1_sensors == PAT_R1_A || r_s1_sensors == PAT_R1_B)) begin
            w_l_off = 9'sd30;   w_r_off = -9'sd30;  w_lock = LOCK_NONE;
        end else if (r_side_lock != LOCK_LEFT
                && (r_s1_sensors == PAT_R2_A || r_s1_sensors == PAT_R2_B)) begin
            w_l_off = 9'sd40;   w_r_off = -9'sd60;  w_lock = LOCK_NONE;
        end else if (r_side_lock != LOCK_LEFT && r_s1_sensors == PAT_R3) begin
            w_l_off = 9'sd50;   w_r_off = -9'sd90;  w_lock = LOCK_NONE;
        end else if (r_side_lock != LOCK_LEFT && r_s1_sensors == PAT_R_EDGE) begin
            w_l_off = 9'sd60;   w_r_off = -9'sd120; w_lock = LOCK_RIGHT;
        end else if (r_side_lock != LOCK_RIGHT && r_s1_sensors == PAT_L1) begin
            w_l_off = -9'sd30;  w_r_off = 9'sd30;   w_lock = LOCK_NONE;
        end else if (r_side_lock != LOCK_RIGHT
                && (r_s1_sensors == PAT_L2_A || r_s1_sensors == PAT_L2_B)) begin
            w_l_off = -9'sd60;  w_r_off = 9'sd40;   w_lock = LOCK_NONE;
        end else if (r_side_lock != LOCK_RIGHT
                && (r_s1_sensors == PAT_L3_A || r_s1_sensors == PAT_L3_B)) begin
            w_l_off = -9'sd90;  w_r_off = 9'sd50;   w_lock = LOCK_NONE;
        end else if (r_side_lock != LOCK_RIGHT && r_s1_sensors == PAT_L_EDGE) begin
            w_l_off = -9'sd120; w_r_off = 9'sd60;   w_lock = LOCK_LEFT;
        end else begin
            w_hit = 1'b0;
        end
    end

    assign w_active = r_run_active || r_s1_start;
    assign w_held   = r_run_held && !r_s1_start;
    assign w_due    = r_last_time + {24'd0, r_update_gap};

    always_comb begin
        n_run_active   = w_active;
        n_run_held     = w_held;
        n_side_lock    = r_side_lock;
        n_white_run    = r_white_run;
        n_left_target  = r_left_target;
        n_right_target = r_right_target;
        n_last_time    = r_last_time;
        n_drive_valid  = 1'b0;
        n_left_drive   = 8'sd0;
        n_right_drive  = 8'sd0;
        n_status       = ST_RUN;
        if (!w_active || w_held) begin
            n_status = w_held ? ST_HELD : ST_IDLE;
        end else if (r_s1_sensors == PAT_DARK) begin
            n_run_active  = 1'b0;
            n_drive_valid = 1'b1;
            n_status      = ST_DARK;
        end else begin
            if (w_hit) begin
                n_left_target  = $signed({2'b00, r_base_speed}) + w_l_off;
                n_right_target = $signed({2'b00, r_base_speed}) + w_r_off;
                n_side_lock    = w_lock;
            end
            if (r_s1_sensors == PAT_WHITE) begin
                if (r_white_run > r_white_limit) begin
                    n_white_run = 8'd0;
                    if (r_tag_mode) begin
                        n_run_active = 1'b0;
                        n_status     = ST_TAG;
                    end else begin
                        n_run_held = 1'b1;
                        n_status   = ST_HELD;
                    end
                end else if (r_white_run != 8'hFF) begin
                    n_white_run = r_white_run + 8'd1;
                end
            end else begin
                n_white_run = 8'd0;
            end
            if (n_run_active) begin
                if (w_due < r_s1_now) begin
                    n_drive_valid = 1'b1;
                    n_left_drive  = clamp_drive(n_left_target);
                    n_right_drive = clamp_drive(n_right_target);
                    n_last_time   = r_s1_now;
                end
            end else begin
                n_drive_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed  <= 7'd0;
            r_white_limit <= 8'd50;
            r_tag_mode    <= 1'b0;
            r_update_gap  <= 8'd2;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_BASE_SPEED:  r_base_speed  <= pwdata[6:0];
                REG_WHITE_LIMIT: r_white_limit <= pwdata[7:0];
                REG_TAG_MODE:    r_tag_mode    <= pwdata[0];
                REG_UPDATE_GAP:  r_update_gap  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_active   <= 1'b0;
            r_run_held     <= 1'b0;
            r_side_lock    <= LOCK_NONE;
            r_white_run    <= 8'd0;
            r_left_target  <= 9'sd0;
            r_right_target <= 9'sd0;
            r_last_time    <= 32'd0;
        end else if (w_s1_adv) begin
            r_run_active   <= n_run_active;
            r_run_held     <= n_run_held;
            r_side_lock    <= n_side_lock;
            r_white_run    <= n_white_run;
            r_left_target  <= n_left_target;
            r_right_target <= n_right_target;
            r_last_time    <= n_last_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_sensors <= i_sensors;
            r_s1_now     <= i_now_ms;
            r_s1_start   <= i_start_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_drive_valid <= n_drive_valid;
            r_left_drive  <= n_left_drive;
            r_right_drive <= n_right_drive;
            r_status      <= n_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_valid = r_drive_valid;
    assign o_left_drive  = r_left_drive;
    assign o_right_drive = r_right_drive;
    assign o_status      = r_status;

endmodule

`default_nettype wire

### rtl/lfds_checker.sv
// ----------------------------------------------------------------------------
// lfds_checker
// Port-level checks on the result channel of the line-follow drive step unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lfds_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic                          o_drive_valid,
    input  wire logic signed [7:0]             o_left_drive,
    input  wire logic signed [7:0]             o_right_drive,
    input  wire logic [2:0]                    o_status
);
    import lfds_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_drive_valid)
            && $stable(o_left_drive) && $stable(o_right_drive) && $stable(o_status))
        else $error("result item changed while stalled");

    // no command means zero drives
    a_quiet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_drive_valid |-> o_left_drive == 8'sd0 && o_right_drive == 8'sd0)
        else $error("nonzero drive without a command");

    // stops always issue a zero drive
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_DARK || o_status == ST_TAG)
            |-> o_drive_valid && o_left_drive == 8'sd0 && o_right_drive == 8'sd0)
        else $error("stop item without a zero drive");

    // a running command is clamped away from zero
    a_run_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_valid && (o_status == ST_RUN || o_status == ST_HELD)
            |-> o_left_drive != 8'sd0 && o_right_drive != 8'sd0
                && o_left_drive <= 8'sd100 && o_left_drive >= -8'sd100
                && o_right_drive <= 8'sd100 && o_right_drive >= -8'sd100)
        else $error("running drive out of clamp range");

    // idle never issues a command
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_IDLE |-> !o_drive_valid)
        else $error("command issued while idle");

endmodule

bind line_follow_drive_step_unit lfds_checker u_lfds_checker (.*);

`default_nettype wire
